/* sv/bounding_box_crop_with_border_assert.svh */
// assertion macros shared by the crop block modules
`ifndef BOUNDING_BOX_CROP_WITH_BORDER_ASSERT_SVH
`define BOUNDING_BOX_CROP_WITH_BORDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBC_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* sv/bbcrop_pkg.sv */
// shared constants and types of the bounding box crop block
package bbcrop_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int PIXEL_BITS = 16;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [1:0] CFG_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_BORDER = 2'd1;
    localparam logic [1:0] CFG_FILL   = 2'd2;

    typedef struct packed {
        logic [8:0]                   height;
        logic [6:0]                   border;
        logic signed [PIXEL_BITS-1:0] fill;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FILL  = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                    kind;
        logic [ADDR_W-1:0]            addr;
        logic signed [PIXEL_BITS-1:0] data;
        logic [8:0]                   rows;
        logic [8:0]                   cols;
        logic                         empty;
        logic                         last;
    } t_cmd;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] value;
        logic [8:0]                   rows;
        logic [8:0]                   cols;
        logic                         empty;
        logic                         last;
    } t_res;

endpackage

/* sv/bounding_box_crop_with_border.sv */
// top level: configuration registers, front, command queue and back
// a request word passes the classify register, queue, read register and output register
// one word is accepted per cycle while the queue has room, loads and requests alike, set by the one frame store port
// a 4-word command queue lets the front keep accepting while the output is held
// synchronous active-low reset clears load position, box, output position and queue
// frame store contents are not cleared; only cells loaded for the current image are read
module bounding_box_crop_with_border (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic                                     i_mode,
    input  logic signed [bbcrop_pkg::PIXEL_BITS-1:0] i_pixel_value,
    input  logic                                     i_last_pixel,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [bbcrop_pkg::PIXEL_BITS-1:0] o_out_value,
    output logic [8:0]                               o_out_rows,
    output logic [8:0]                               o_out_cols,
    output logic                                     o_empty_image,
    output logic                                     o_last_out,
    input  logic                                     i_cfg_we,
    input  logic [1:0]                               i_cfg_index,
    input  logic [15:0]                              i_cfg_data
);

    bbcrop_pkg::t_cfg r_cfg;
    logic             q_push, q_ready, q_valid, q_pop, q_wr;
    bbcrop_pkg::t_cmd q_in, q_out;
    bbcrop_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height <= 9'd256;
            r_cfg.border <= 7'd1;
            r_cfg.fill   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbcrop_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data[8:0];
                bbcrop_pkg::CFG_BORDER: r_cfg.border <= i_cfg_data[6:0];
                bbcrop_pkg::CFG_FILL:   r_cfg.fill   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a held command enters the queue only once there is room
    assign q_wr = q_push && q_ready;

    bbcrop_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .i_cfg         (r_cfg),
        .o_q_valid     (q_push),
        .o_q_cmd       (q_in),
        .i_q_ready     (q_ready)
    );

    bbcrop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_wr),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    bbcrop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_out_value   = res.value;
    assign o_out_rows    = res.rows;
    assign o_out_cols    = res.cols;
    assign o_empty_image = res.empty;
    assign o_last_out    = res.last;

endmodule

/* sv/bbcrop_fifo.sv */
// command queue between the classifying front and the memory back
`include "bounding_box_crop_with_border_assert.svh"
module bbcrop_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bbcrop_pkg::t_cmd  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output bbcrop_pkg::t_cmd  o_data,
    input  logic              i_pop
);

    bbcrop_pkg::t_cmd                     r_mem [bbcrop_pkg::Q_DEPTH];
    logic [bbcrop_pkg::Q_PTR_W-1:0]       r_wptr;
    logic [bbcrop_pkg::Q_PTR_W-1:0]       r_rptr;
    logic [bbcrop_pkg::Q_PTR_W:0]         r_count;

    assign o_ready = (r_count != (bbcrop_pkg::Q_PTR_W+1)'(bbcrop_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `BBC_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !o_ready, "push into full queue")
    `BBC_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `BBC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (bbcrop_pkg::Q_PTR_W+1)'(bbcrop_pkg::Q_DEPTH), "queue count out of range")

endmodule

/* sv/bbcrop_front.sv */
// front part: load tracking, bounding box, output position and command build
`include "bounding_box_crop_with_border_assert.svh"
module bbcrop_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic signed [bbcrop_pkg::PIXEL_BITS-1:0] i_pixel_value,
    input  logic                                  i_last_pixel,
    input  bbcrop_pkg::t_cfg                      i_cfg,
    output logic                                  o_q_valid,
    output bbcrop_pkg::t_cmd                      o_q_cmd,
    input  logic                                  i_q_ready
);

    // load and box state
    logic [bbcrop_pkg::ROW_W-1:0] r_load_row, n_load_row;
    logic [8:0]                   r_load_col, n_load_col;
    logic                         r_load_done, n_load_done;
    logic                         r_box_valid, n_box_valid;
    logic [8:0]                   r_row_min, n_row_min, r_row_max, n_row_max;
    logic [8:0]                   r_col_min, n_col_min, r_col_max, n_col_max;
    logic [8:0]                   r_emit_row, n_emit_row, r_emit_col, n_emit_col;

    // classify stage
    logic                             r_b_valid, n_b_valid;
    logic                             r_b_write, n_b_write;
    logic [bbcrop_pkg::ADDR_W-1:0]    r_b_waddr, n_b_waddr;
    logic signed [bbcrop_pkg::PIXEL_BITS-1:0] r_b_wdata, n_b_wdata;
    logic [8:0]                       r_b_r, n_b_r, r_b_c, n_b_c;
    logic [8:0]                       r_b_rows, n_b_rows, r_b_cols, n_b_cols;
    logic [6:0]                       r_b_border, n_b_border;
    logic                             r_b_box_valid, n_b_box_valid;
    logic [bbcrop_pkg::ROW_W-1:0]     r_b_row_min, n_b_row_min;
    logic [bbcrop_pkg::COL_W-1:0]     r_b_col_min, n_b_col_min;

    logic       accept;
    logic [8:0] eff_h;
    logic [8:0] twob;
    logic [8:0] rows, cols;
    logic [8:0] er, ec;
    logic [8:0] row_inc, er_inc, ec_inc;
    logic [bbcrop_pkg::ROW_W-1:0] c_row;
    logic [8:0] c_col;
    logic       c_bv;
    logic       positive;

    logic [8:0] bb;
    logic [8:0] off_r, off_c;
    logic       in_win;
    logic [bbcrop_pkg::ROW_W-1:0] sr;
    logic [bbcrop_pkg::COL_W-1:0] sc;
    logic       loaded;

    assign o_in_ready = !r_b_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_cfg.height == 9'd0) begin
            eff_h = 9'd1;
        end else if (i_cfg.height > 9'(bbcrop_pkg::MAX_ROWS)) begin
            eff_h = 9'(bbcrop_pkg::MAX_ROWS);
        end else begin
            eff_h = i_cfg.height;
        end
    end

    assign twob = {1'b0, i_cfg.border, 1'b0};
    assign rows = r_box_valid ? (r_row_max - r_row_min + 9'd1 + twob) : twob;
    assign cols = r_box_valid ? (r_col_max - r_col_min + 9'd1 + twob) : twob;
    assign positive = !i_pixel_value[bbcrop_pkg::PIXEL_BITS-1] && (i_pixel_value != '0);

    // a load after the last pixel starts a new image
    assign c_row = r_load_done ? '0 : r_load_row;
    assign c_col = r_load_done ? '0 : r_load_col;
    assign c_bv  = r_load_done ? 1'b0 : r_box_valid;
    assign row_inc = {1'b0, c_row} + 9'd1;

    // wrap the output position when the output size shrank
    assign er = (r_emit_row >= rows || r_emit_col >= cols) ? 9'd0 : r_emit_row;
    assign ec = (r_emit_row >= rows || r_emit_col >= cols) ? 9'd0 : r_emit_col;
    assign er_inc = er + 9'd1;
    assign ec_inc = ec + 9'd1;

    always_comb begin
        n_load_row  = r_load_row;
        n_load_col  = r_load_col;
        n_load_done = r_load_done;
        n_box_valid = r_box_valid;
        n_row_min   = r_row_min;
        n_row_max   = r_row_max;
        n_col_min   = r_col_min;
        n_col_max   = r_col_max;
        n_emit_row  = r_emit_row;
        n_emit_col  = r_emit_col;

        n_b_valid     = r_b_valid && !i_q_ready;
        n_b_write     = r_b_write;
        n_b_waddr     = r_b_waddr;
        n_b_wdata     = r_b_wdata;
        n_b_r         = r_b_r;
        n_b_c         = r_b_c;
        n_b_rows      = r_b_rows;
        n_b_cols      = r_b_cols;
        n_b_border    = r_b_border;
        n_b_box_valid = r_b_box_valid;
        n_b_row_min   = r_b_row_min;
        n_b_col_min   = r_b_col_min;

        if (accept && !i_mode) begin
            n_load_row  = c_row;
            n_load_col  = c_col;
            n_load_done = i_last_pixel;
            if (r_load_done) begin
                n_box_valid = 1'b0;
                n_row_min   = 9'(bbcrop_pkg::MAX_ROWS);
                n_col_min   = 9'(bbcrop_pkg::MAX_COLS);
                n_row_max   = '1;
                n_col_max   = '1;
                n_emit_row  = '0;
                n_emit_col  = '0;
            end
            if (c_col < 9'(bbcrop_pkg::MAX_COLS)) begin
                n_b_valid = 1'b1;
                n_b_write = 1'b1;
                n_b_waddr = {c_col[bbcrop_pkg::COL_W-1:0], c_row};
                n_b_wdata = i_pixel_value;
                if (positive) begin
                    n_box_valid = 1'b1;
                    if (!c_bv) begin
                        n_row_min = {1'b0, c_row};
                        n_row_max = {1'b0, c_row};
                        n_col_min = c_col;
                        n_col_max = c_col;
                    end else begin
                        if ({1'b0, c_row} < r_row_min) n_row_min = {1'b0, c_row};
                        if ({1'b0, c_row} > r_row_max) n_row_max = {1'b0, c_row};
                        if (c_col < r_col_min) n_col_min = c_col;
                        if (c_col > r_col_max) n_col_max = c_col;
                    end
                end
                if (row_inc >= eff_h) begin
                    n_load_row = '0;
                    n_load_col = c_col + 9'd1;
                end else begin
                    n_load_row = row_inc[bbcrop_pkg::ROW_W-1:0];
                end
            end
        end else if (accept && i_mode && rows != 9'd0 && cols != 9'd0) begin
            n_b_valid     = 1'b1;
            n_b_write     = 1'b0;
            n_b_r         = er;
            n_b_c         = ec;
            n_b_rows      = rows;
            n_b_cols      = cols;
            n_b_border    = i_cfg.border;
            n_b_box_valid = r_box_valid;
            n_b_row_min   = r_row_min[bbcrop_pkg::ROW_W-1:0];
            n_b_col_min   = r_col_min[bbcrop_pkg::COL_W-1:0];
            if (er_inc >= rows) begin
                n_emit_row = '0;
                n_emit_col = (ec_inc >= cols) ? 9'd0 : ec_inc;
            end else begin
                n_emit_row = er_inc;
                n_emit_col = ec;
            end
        end
    end

    // classify a read: border, unloaded cell or stored pixel
    assign bb     = {2'b0, r_b_border};
    assign in_win = r_b_box_valid && (r_b_r >= bb) && (r_b_r < r_b_rows - bb)
                    && (r_b_c >= bb) && (r_b_c < r_b_cols - bb);
    assign off_r  = r_b_r - bb;
    assign off_c  = r_b_c - bb;
    assign sr     = r_b_row_min + off_r[bbcrop_pkg::ROW_W-1:0];
    assign sc     = r_b_col_min + off_c[bbcrop_pkg::COL_W-1:0];
    assign loaded = ({1'b0, sc} < r_load_col)
                    || (({1'b0, sc} == r_load_col) && (sr < r_load_row));

    always_comb begin
        o_q_cmd.rows  = r_b_rows;
        o_q_cmd.cols  = r_b_cols;
        o_q_cmd.empty = !r_b_box_valid;
        o_q_cmd.last  = (r_b_r == r_b_rows - 9'd1) && (r_b_c == r_b_cols - 9'd1);
        o_q_cmd.addr  = {sc, sr};
        o_q_cmd.data  = i_cfg.fill;
        o_q_cmd.kind  = bbcrop_pkg::CMD_FILL;
        if (r_b_write) begin
            o_q_cmd.kind = bbcrop_pkg::CMD_WRITE;
            o_q_cmd.addr = r_b_waddr;
            o_q_cmd.data = r_b_wdata;
        end else if (in_win && loaded) begin
            o_q_cmd.kind = bbcrop_pkg::CMD_READ;
        end else if (in_win) begin
            o_q_cmd.data = '0;
        end
    end

    assign o_q_valid = r_b_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_row  <= '0;
            r_load_col  <= '0;
            r_load_done <= 1'b0;
            r_box_valid <= 1'b0;
            r_row_min   <= 9'(bbcrop_pkg::MAX_ROWS);
            r_col_min   <= 9'(bbcrop_pkg::MAX_COLS);
            r_row_max   <= '1;
            r_col_max   <= '1;
            r_emit_row  <= '0;
            r_emit_col  <= '0;
            r_b_valid   <= 1'b0;
        end else begin
            r_load_row  <= n_load_row;
            r_load_col  <= n_load_col;
            r_load_done <= n_load_done;
            r_box_valid <= n_box_valid;
            r_row_min   <= n_row_min;
            r_col_min   <= n_col_min;
            r_row_max   <= n_row_max;
            r_col_max   <= n_col_max;
            r_emit_row  <= n_emit_row;
            r_emit_col  <= n_emit_col;
            r_b_valid   <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_write     <= n_b_write;
        r_b_waddr     <= n_b_waddr;
        r_b_wdata     <= n_b_wdata;
        r_b_r         <= n_b_r;
        r_b_c         <= n_b_c;
        r_b_rows      <= n_b_rows;
        r_b_cols      <= n_b_cols;
        r_b_border    <= n_b_border;
        r_b_box_valid <= n_b_box_valid;
        r_b_row_min   <= n_b_row_min;
        r_b_col_min   <= n_b_col_min;
    end

    `BBC_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, (r_b_valid && !i_q_ready) |-> !o_in_ready, "input taken while command stalled")
    `BBC_ASSERT(a_box_ordered, i_clk, i_rst_n, r_box_valid |-> (r_row_min <= r_row_max && r_col_min <= r_col_max), "bounding box corners out of order")

endmodule

/* sv/bbcrop_back.sv */
// back part: frame store access and output register
`include "bounding_box_crop_with_border_assert.svh"
module bbcrop_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  bbcrop_pkg::t_cmd  i_q_cmd,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bbcrop_pkg::t_res  o_res
);

    logic signed [bbcrop_pkg::PIXEL_BITS-1:0] r_mem [2**bbcrop_pkg::ADDR_W];
    logic signed [bbcrop_pkg::PIXEL_BITS-1:0] r_rdata;
    logic              r_r_valid;
    bbcrop_pkg::t_cmd  r_r_cmd;
    logic              r_o_valid;
    bbcrop_pkg::t_res  r_o;
    logic              adv;

    assign adv     = r_r_valid && (!r_o_valid || i_out_ready);
    assign o_q_pop = i_q_valid && (!r_r_valid || adv);

    // one port: a write or a read per popped word
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_cmd.kind == bbcrop_pkg::CMD_WRITE) begin
                r_mem[i_q_cmd.addr] <= i_q_cmd.data;
            end else begin
                r_rdata <= r_mem[i_q_cmd.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_r_cmd <= i_q_cmd;
        end
        if (adv) begin
            r_o.value <= (r_r_cmd.kind == bbcrop_pkg::CMD_READ) ? r_rdata : r_r_cmd.data;
            r_o.rows  <= r_r_cmd.rows;
            r_o.cols  <= r_r_cmd.cols;
            r_o.empty <= r_r_cmd.empty;
            r_o.last  <= r_r_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_r_valid <= (i_q_cmd.kind != bbcrop_pkg::CMD_WRITE);
            end else if (adv) begin
                r_r_valid <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_res       = r_o;

    `BBC_ASSERT(a_read_lands, i_clk, i_rst_n, (o_q_pop && i_q_cmd.kind != bbcrop_pkg::CMD_WRITE) |=> r_r_valid, "popped read lost")
    `BBC_ASSERT(a_write_silent, i_clk, i_rst_n, (o_q_pop && i_q_cmd.kind == bbcrop_pkg::CMD_WRITE) |=> !r_r_valid, "write produced a result")

endmodule

/* dv/tb_bounding_box_crop_with_border.sv */
`timescale 1ns / 1ps
// self-checking testbench of the bounding box crop block: directed table, then fixed phases, then random phases
module tb_bounding_box_crop_with_border;

    localparam int RANDOM_WORDS = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_DIR        = 22;

    typedef struct packed {
        bit               mode;
        bit signed [15:0] pix;
        bit               lastp;
        bit               typed;
        bit signed [15:0] e_value;
        bit [8:0]         e_rows;
        bit [8:0]         e_cols;
        bit               e_empty;
        bit               e_last;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_mode = 1'b0;
    logic signed [15:0]     i_pixel_value = '0;
    logic                   i_last_pixel = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic signed [15:0]     o_out_value;
    logic [8:0]             o_out_rows;
    logic [8:0]             o_out_cols;
    logic                   o_empty_image;
    logic                   o_last_out;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_index = '0;
    logic [15:0]            i_cfg_data = '0;

    bounding_box_crop_with_border dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_value   (o_out_value),
        .o_out_rows    (o_out_rows),
        .o_out_cols    (o_out_cols),
        .o_empty_image (o_empty_image),
        .o_last_out    (o_last_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // crop predictor state
    bit signed [15:0] frame_mem [bbcrop_pkg::MAX_ROWS*bbcrop_pkg::MAX_COLS];
    int unsigned      ld_row, ld_col, rd_row, rd_col;
    int unsigned      box_top, box_bot, box_lft, box_rgt;
    bit               ld_done, box_ok;
    int unsigned      cfg_height, cfg_border;
    bit signed [15:0] cfg_fill;

    bbcrop_pkg::t_res exp_pixels [$];
    int               mismatches = 0;
    int               words_sent = 0;
    bit               steady_run = 1'b0;
    bit               hold_off_req = 1'b0;

    // after reset, extremes and the new-image restart; blank rows go through the predictor
    t_dir_row dir_tab [N_DIR] = '{
        '{1'b1, 16'sh1234, 1'b1, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0},
        '{1'b1, 16'shFFFF, 1'b0, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0},
        '{1'b1, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b1},
        '{1'b1, 16'sh7FFF, 1'b0, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0},
        '{1'b0, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'sh7FFF, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'sh0001, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'shFFFF, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'sh0005, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'shAAAA, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh5555, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b0, 16'sh0000, 1'b1, 1'b0, 16'sh0000, 9'd0, 9'd0, 1'b0, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0},
        '{1'b1, 16'sh0000, 1'b0, 1'b1, 16'sh0000, 9'd2, 9'd2, 1'b1, 1'b0}
    };

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned height_eff(input int unsigned h);
        if (h == 0) return 1;
        if (h > bbcrop_pkg::MAX_ROWS) return bbcrop_pkg::MAX_ROWS;
        return h;
    endfunction

    function automatic void out_dims(output int unsigned rows, output int unsigned cols);
        if (box_ok) begin
            rows = box_bot - box_top + 1 + 2 * cfg_border;
            cols = box_rgt - box_lft + 1 + 2 * cfg_border;
        end else begin
            rows = 2 * cfg_border;
            cols = 2 * cfg_border;
        end
    endfunction

    // one accepted word: loads and zero-size requests return 0, other requests 1 with the expected pixel
    function automatic bit crop_step(input bit mode, input bit signed [15:0] pix,
                                     input bit lastp, output bbcrop_pkg::t_res res);
        int unsigned      rows, cols, r, c, sr, sc, b;
        bit signed [15:0] val;
        bit               at_end;
        res = '0;
        b = cfg_border;
        if (!mode) begin
            if (ld_done) begin
                ld_row = 0;
                ld_col = 0;
                box_ok = 1'b0;
                rd_row = 0;
                rd_col = 0;
                ld_done = 1'b0;
            end
            if (ld_col < bbcrop_pkg::MAX_COLS) begin
                frame_mem[ld_col * bbcrop_pkg::MAX_ROWS + ld_row] = pix;
                if (pix > 0) begin
                    if (!box_ok) begin
                        box_ok = 1'b1;
                        box_top = ld_row;
                        box_bot = ld_row;
                        box_lft = ld_col;
                        box_rgt = ld_col;
                    end else begin
                        if (ld_row < box_top) box_top = ld_row;
                        if (ld_row > box_bot) box_bot = ld_row;
                        if (ld_col < box_lft) box_lft = ld_col;
                        if (ld_col > box_rgt) box_rgt = ld_col;
                    end
                end
                ld_row++;
                if (ld_row >= height_eff(cfg_height)) begin
                    ld_row = 0;
                    ld_col++;
                end
            end
            if (lastp) ld_done = 1'b1;
            return 1'b0;
        end
        out_dims(rows, cols);
        if (rows == 0 || cols == 0) return 1'b0;
        // output size changed under the read position
        if (rd_row >= rows || rd_col >= cols) begin
            rd_row = 0;
            rd_col = 0;
        end
        r = rd_row;
        c = rd_col;
        val = cfg_fill;
        if (box_ok && r >= b && r < rows - b && c >= b && c < cols - b) begin
            sr = box_top + r - b;
            sc = box_lft + c - b;
            // cells not yet loaded in this image read as zero
            if (sr < bbcrop_pkg::MAX_ROWS && sc < bbcrop_pkg::MAX_COLS
                && (sc < ld_col || (sc == ld_col && sr < ld_row)))
                val = frame_mem[sc * bbcrop_pkg::MAX_ROWS + sr];
            else
                val = 16'sh0000;
        end
        at_end = (r == rows - 1) && (c == cols - 1);
        rd_row++;
        if (rd_row >= rows) begin
            rd_row = 0;
            rd_col++;
            if (rd_col >= cols) rd_col = 0;
        end
        res.value = val;
        res.rows  = rows[8:0];
        res.cols  = cols[8:0];
        res.empty = !box_ok;
        res.last  = at_end;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit signed [15:0] pick_pixel(input int pos_pct);
        int v;
        if ($urandom_range(0, 99) < pos_pct) return 16'($urandom_range(1, 32767));
        v = $urandom_range(0, 32768);
        return 16'(-v);
    endfunction

    task automatic put_word(input bit mode, input bit signed [15:0] pix, input bit lastp,
                            input bit typed, input bbcrop_pkg::t_res typed_res);
        int               gap;
        bbcrop_pkg::t_res res;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_pixel_value <= pix;
        i_last_pixel  <= lastp;
        do @(posedge i_clk); while (!o_in_ready);
        if (crop_step(mode, pix, lastp, res))
            exp_pixels.push_back(typed ? typed_res : res);
        words_sent++;
    endtask

    task automatic put_request();
        put_word(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // stop offering words and let every expected pixel drain
    task automatic settle();
        i_in_valid <= 1'b0;
        while (exp_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            bbcrop_pkg::CFG_HEIGHT: cfg_height = data[8:0];
            bbcrop_pkg::CFG_BORDER: cfg_border = data[6:0];
            bbcrop_pkg::CFG_FILL:   cfg_fill = data;
            default: ;
        endcase
    endtask

    // nreads below zero: read the whole output, plus up to four words more, when it is small
    task automatic run_phase(input int h, input int b, input int f, input int ncols,
                             input int pos_pct, input bit corners, input bit with_last,
                             input int nreads, input bit mix, input bit hold);
        int          eff, npx, top, nrd;
        int unsigned rows, cols;
        bit signed [15:0] pix;
        settle();
        write_reg(bbcrop_pkg::CFG_HEIGHT, 16'(h & 'h1FF));
        write_reg(bbcrop_pkg::CFG_BORDER, 16'(b & 'h7F));
        write_reg(bbcrop_pkg::CFG_FILL, 16'(f));
        i_cfg_we <= 1'b0;
        eff = height_eff(cfg_height);
        npx = ncols * eff;
        // partial last column
        if (ncols > 1 && eff > 1 && $urandom_range(0, 2) == 0)
            npx -= $urandom_range(1, eff - 1);
        top = (npx < eff * bbcrop_pkg::MAX_COLS ? npx : eff * bbcrop_pkg::MAX_COLS) - 1;
        for (int i = 0; i < npx; i++) begin
            if (mix && $urandom_range(0, 9) == 0) put_request();
            if (corners && (i == 0 || i == top)) pix = 16'($urandom_range(1, 32767));
            else pix = pick_pixel(pos_pct);
            put_word(1'b0, pix, with_last && i == npx - 1, 1'b0, '0);
        end
        if (nreads < 0) begin
            out_dims(rows, cols);
            if (rows * cols <= 120) nrd = rows * cols + $urandom_range(0, 4);
            else nrd = $urandom_range(10, 60);
        end else begin
            nrd = nreads;
        end
        if (hold) hold_off_req = 1'b1;
        for (int i = 0; i < nrd; i++) put_request();
    endtask

    initial begin : out_side
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (steady_run) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge i_clk);
                i_out_ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        bbcrop_pkg::t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_pixels.size() == 0) begin
                $error("output word with none expected: out_value %0d", o_out_value);
                mismatches++;
            end else begin
                want = exp_pixels.pop_front();
                if (o_out_value !== want.value) begin
                    $error("out_value: expected %0d, got %0d", want.value, o_out_value);
                    mismatches++;
                end
                if (o_out_rows !== want.rows) begin
                    $error("out_rows: expected %0d, got %0d", want.rows, o_out_rows);
                    mismatches++;
                end
                if (o_out_cols !== want.cols) begin
                    $error("out_cols: expected %0d, got %0d", want.cols, o_out_cols);
                    mismatches++;
                end
                if (o_empty_image !== want.empty) begin
                    $error("empty_image: expected %0d, got %0d", want.empty, o_empty_image);
                    mismatches++;
                end
                if (o_last_out !== want.last) begin
                    $error("last_out: expected %0d, got %0d", want.last, o_last_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        bbcrop_pkg::t_res want;
        int   base, phase_no, h, b, eff, ncols, pct;
        bit   corners, with_last, mix, hold;
        ld_row = 0;
        ld_col = 0;
        ld_done = 1'b0;
        box_ok = 1'b0;
        rd_row = 0;
        rd_col = 0;
        cfg_height = 256;
        cfg_border = 1;
        cfg_fill = 16'sh0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            want.value = dir_tab[k].e_value;
            want.rows  = dir_tab[k].e_rows;
            want.cols  = dir_tab[k].e_cols;
            want.empty = dir_tab[k].e_empty;
            want.last  = dir_tab[k].e_last;
            put_word(dir_tab[k].mode, dir_tab[k].pix, dir_tab[k].lastp, dir_tab[k].typed, want);
        end

        // height 0 acts as 1, fill at its minimum, no border
        run_phase(0, 0, 'h8000, 3, 50, 1'b1, 1'b1, 20, 1'b0, 1'b0);
        // empty image with no border: requests give nothing
        run_phase(1, 0, 'h0000, 2, 0, 1'b0, 1'b1, 6, 1'b0, 1'b0);
        // more columns than the store holds, widest output
        run_phase(1, 64, 'h7FFF, 260, 30, 1'b1, 1'b1, 200, 1'b0, 1'b0);
        // border shrinks under the read position, no reload
        run_phase(1, 0, 'h5555, 0, 0, 1'b0, 1'b0, 10, 1'b0, 1'b0);
        // height above the maximum, tallest output
        run_phase(511, 64, 'hFFFF, 1, 5, 1'b1, 1'b1, 40, 1'b0, 1'b0);
        run_phase(256, 63, 'h2AAA, 1, 20, 1'b0, 1'b1, 20, 1'b1, 1'b0);
        // long receiver hold while requests keep coming
        run_phase(4, 3, $urandom, 5, 40, 1'b1, 1'b1, 150, 1'b0, 1'b1);

        base = words_sent;
        phase_no = 0;
        while (words_sent - base < RANDOM_WORDS) begin
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 8);
            // height stays put while an image is half loaded
            if (!ld_done && (ld_row != 0 || ld_col != 0)) h = cfg_height;
            b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 3);
            eff = height_eff(h);
            if ($urandom_range(0, 4) == 0) ncols = 0;
            else ncols = (eff > 16) ? 1 : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: pct = 0;
                1: pct = 10;
                2: pct = 40;
                default: pct = 90;
            endcase
            corners   = ($urandom_range(0, 3) == 0);
            with_last = ($urandom_range(0, 6) != 0);
            mix       = ($urandom_range(0, 2) == 0);
            hold      = (phase_no % 40 == 3);
            steady_run = ($urandom_range(0, 6) == 0);
            run_phase(h, b, $urandom, ncols, pct, corners, with_last, -1, mix, hold);
            phase_no++;
        end
        steady_run = 1'b0;

        settle();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* bounding_box_crop_with_border.f */
+incdir+sv
sv/bbcrop_pkg.sv
sv/bbcrop_fifo.sv
sv/bbcrop_front.sv
sv/bbcrop_back.sv
sv/bounding_box_crop_with_border.sv
dv/tb_bounding_box_crop_with_border.sv
